### hdl/rrv_pkg.sv
// rrv_pkg: command and status codes, plus the control word broadcast to the cells,
// for the ranked ring vector.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package rrv_pkg;

    // Command codes carried by an input item
    typedef enum logic [1:0] {
        CMD_GET    = 2'd0,
        CMD_SET    = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_RANK = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    // Commit strobes broadcast to every cell along with the rank
    typedef struct packed {
        logic ins;   // open a gap at rank, later cells take from their lower neighbor
        logic rem;   // close the gap at rank, cells at or above take from upper neighbor
        logic set;   // overwrite the cell at rank
    } t_cell_ctrl;

endpackage

`default_nettype wire

### hdl/rrv_if.sv
// rrv_cmd_if and rrv_rsp_if: valid/ready channels for command and result items.
// Depends on rrv_pkg for the command and status types.
`default_nettype none

interface rrv_cmd_if #(
    parameter int RANK_W  = 7,
    parameter int VALUE_W = 32
) ();
    logic               valid;
    logic               ready;
    rrv_pkg::t_cmd      command;
    logic [RANK_W-1:0]  rank;
    logic [VALUE_W-1:0] value_in;

    modport source (output valid, output command, output rank, output value_in, input ready);
    modport sink   (input valid, input command, input rank, input value_in, output ready);
endinterface

interface rrv_rsp_if #(
    parameter int RANK_W  = 7,
    parameter int VALUE_W = 32
) ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value_out;
    rrv_pkg::t_status   status;
    logic [RANK_W-1:0]  element_count;

    modport source (output valid, output value_out, output status, output element_count,
                    input ready);
    modport sink   (input valid, input value_out, input status, input element_count,
                     output ready);
endinterface

`default_nettype wire

### hdl/rrv_cell.sv
// rrv_cell: one storage cell of the vector, holding the element at rank INDEX.
// Depends on rrv_pkg for the broadcast control word.
`default_nettype none

module rrv_cell #(
    parameter int INDEX       = 0,
    parameter int RANK_W      = 7,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire rrv_pkg::t_cell_ctrl    i_ctrl,
    input  wire logic [RANK_W-1:0]      i_rank,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic [VALUE_WIDTH-1:0] i_prev,
    input  wire logic [VALUE_WIDTH-1:0] i_next,
    output logic      [VALUE_WIDTH-1:0] o_value,
    output logic      [VALUE_WIDTH-1:0] o_sel
);

    localparam logic [RANK_W-1:0] MY_RANK = RANK_W'(INDEX);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic                   w_hit;
    logic                   w_above;

    assign w_hit   = (i_rank == MY_RANK);
    assign w_above = (MY_RANK > i_rank);

    // Pick the next content from the command and this cell's place against the rank
    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins) begin
            if (w_hit) begin
                n_value = i_value;
            end else if (w_above) begin
                n_value = i_prev;
            end
        end else if (i_ctrl.rem) begin
            if (w_hit || w_above) begin
                n_value = i_next;
            end
        end else if (i_ctrl.set && w_hit) begin
            n_value = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // Hand the content to both neighbors; drive the read bus only when addressed
    assign o_value = r_value;
    assign o_sel   = w_hit ? r_value : '0;

endmodule

`default_nettype wire

### hdl/ranked_ring_vector.sv
// ranked_ring_vector: rank-addressed vector built as a row of shifting cells.
// Depends on rrv_pkg, rrv_cmd_if / rrv_rsp_if and rrv_cell.
//
//   channel   dir  handshake      payload
//   i_cmd     in   valid / ready  command, rank, value_in
//   o_rsp     out  valid / ready  value_out, status, element_count
//
// One command per cycle while i_cmd.ready is high: every cell loads from itself,
// its lower or upper neighbor or the input value in the same cycle, so insert and
// remove shift the whole row at once. The result lands in an output register in the
// cycle after acceptance. i_cmd.ready is high while the output register is empty or
// being taken. Synchronous reset empties the vector; cell contents are not cleared.
`default_nettype none

module ranked_ring_vector #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rrv_cmd_if.sink    i_cmd,
    rrv_rsp_if.source  o_rsp
);

    localparam int RANK_W = $clog2(CAPACITY + 1);
    localparam logic [RANK_W-1:0] CAP_CNT = RANK_W'(CAPACITY);

    logic [RANK_W-1:0]      r_count;
    logic [RANK_W-1:0]      n_count;
    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_value_out;
    rrv_pkg::t_status       r_status;
    rrv_pkg::t_status       n_status;
    rrv_pkg::t_cell_ctrl    w_ctrl;
    logic                   w_accept;
    logic                   w_is_ins;
    logic                   w_bad_rank;
    logic                   w_ok;
    logic [VALUE_WIDTH-1:0] w_read;

    logic [VALUE_WIDTH-1:0] w_cell_val [CAPACITY];
    logic [VALUE_WIDTH-1:0] w_cell_sel [CAPACITY];

    // Accept a new item while the result register is free or draining
    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    // Check rank, then room
    assign w_is_ins   = (i_cmd.command == rrv_pkg::CMD_INSERT);
    assign w_bad_rank = w_is_ins ? (i_cmd.rank > r_count) : (i_cmd.rank >= r_count);

    always_comb begin
        n_status = rrv_pkg::ST_OK;
        if (w_bad_rank) begin
            n_status = rrv_pkg::ST_BAD_RANK;
        end else if (w_is_ins && (r_count == CAP_CNT)) begin
            n_status = rrv_pkg::ST_FULL;
        end
    end

    assign w_ok = (n_status == rrv_pkg::ST_OK);

    // Commit strobes for the cell row
    always_comb begin
        w_ctrl     = '0;
        w_ctrl.ins = w_accept && w_ok && (i_cmd.command == rrv_pkg::CMD_INSERT);
        w_ctrl.rem = w_accept && w_ok && (i_cmd.command == rrv_pkg::CMD_REMOVE);
        w_ctrl.set = w_accept && w_ok && (i_cmd.command == rrv_pkg::CMD_SET);
    end

    // Row of cells, each wired to its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_prev;
        logic [VALUE_WIDTH-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_lo
            assign w_prev = w_cell_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_hi
            assign w_next = w_cell_val[g+1];
        end

        rrv_cell #(
            .INDEX       (g),
            .RANK_W      (RANK_W),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_rank  (i_cmd.rank),
            .i_value (i_cmd.value_in),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_value (w_cell_val[g]),
            .o_sel   (w_cell_sel[g])
        );
    end

    // Gather the addressed cell from the read bus
    always_comb begin
        w_read = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_read = w_read | w_cell_sel[k];
        end
    end

    // Element count after the command
    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + RANK_W'(1);
        end else if (w_ctrl.rem) begin
            n_count = r_count - RANK_W'(1);
        end
    end

    // Control state: count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; insert and errors report zero
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_value_out <= (w_ok && !w_is_ins) ? w_read : '0;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.value_out     = r_value_out;
    assign o_rsp.status        = r_status;
    assign o_rsp.element_count = r_count;

    // The vector never holds more than the row of cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("element count beyond capacity");

    // A committed insert grows the vector by exactly one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ins |=> (r_count == $past(r_count) + RANK_W'(1)))
        else $error("insert did not grow count by one");

    // A failed command leaves the count alone
    a_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_ok) |=> (r_count == $past(r_count)))
        else $error("failed command changed the count");

    // Error results carry a zero value
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != rrv_pkg::ST_OK)) |-> (r_value_out == '0))
        else $error("error result with nonzero value");

endmodule

`default_nettype wire
